### rtl/mih_pkg.sv
// types, codes and constants shared by the motion idle hold timer
package mih_pkg;

  localparam int unsigned NumAxes      = 2;
  localparam int unsigned TickW        = 32;
  localparam int unsigned DelayW       = 16;
  localparam logic [DelayW-1:0] HoldDelayRst = 16'd250;

  typedef enum logic [1:0] {
    FUNC_POLL    = 2'd0,
    FUNC_SERVICE = 2'd1,
    FUNC_BEGIN   = 2'd2,
    FUNC_TAKE    = 2'd3
  } func_e;

  typedef struct packed {
    func_e                    func;
    logic [TickW-1:0]         now_ms;
    logic [NumAxes-1:0]       running;
    logic [NumAxes-1:0]       idle;
  } item_t;

  typedef struct packed {
    logic [NumAxes-1:0]       hold_current;
    logic                     motion_finished;
    logic                     any_running;
    logic [TickW-1:0]         last_runtime_ms;
  } res_t;

endpackage

### rtl/mih_if.sv
// handshake channel interfaces for the motion idle hold timer
interface mih_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [31:0] now_ms;
  logic        running_x;
  logic        running_y;
  logic        idle_x;
  logic        idle_y;

  modport source (output valid, func, now_ms, running_x, running_y, idle_x, idle_y,
                  input ready);
  modport sink   (input valid, func, now_ms, running_x, running_y, idle_x, idle_y,
                  output ready);
endinterface

interface mih_out_if;
  logic        valid;
  logic        ready;
  logic        hold_current_x;
  logic        hold_current_y;
  logic        motion_finished;
  logic        any_running;
  logic [31:0] last_runtime_ms;

  modport source (output valid, hold_current_x, hold_current_y, motion_finished,
                  any_running, last_runtime_ms, input ready);
  modport sink   (input valid, hold_current_x, hold_current_y, motion_finished,
                  any_running, last_runtime_ms, output ready);
endinterface

interface mih_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

### rtl/mih_step.sv
// per-word state update: edge detection, hold deadlines, runtime and done flag
module mih_step
  import mih_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  item_t             item_i,
  input  logic [DelayW-1:0] hold_delay_i,
  output res_t              res_o
);

  logic [NumAxes-1:0] prev_run_q, prev_run_d;
  logic [NumAxes-1:0] armed_q, armed_d;
  logic [TickW-1:0]   deadline_q [NumAxes];
  logic [TickW-1:0]   deadline_d [NumAxes];
  logic               prev_any_q, prev_any_d;
  logic [TickW-1:0]   start_q, start_d;
  logic [TickW-1:0]   latched_q, latched_d;
  logic               rt_armed_q, rt_armed_d;
  logic               done_q, done_d;

  logic               any_run;
  logic [NumAxes-1:0] pulse;
  logic [TickW-1:0]   diff [NumAxes];
  logic               finished;

  assign any_run = |item_i.running;

  always_comb begin
    prev_run_d = prev_run_q;
    armed_d    = armed_q;
    deadline_d = deadline_q;
    prev_any_d = prev_any_q;
    start_d    = start_q;
    latched_d  = latched_q;
    rt_armed_d = rt_armed_q;
    done_d     = done_q;
    pulse      = '0;
    finished   = 1'b0;
    for (int ax = 0; ax < NumAxes; ax++) begin
      diff[ax] = item_i.now_ms - deadline_q[ax];
    end
    unique case (item_i.func)
      FUNC_POLL: begin
        for (int ax = 0; ax < NumAxes; ax++) begin
          if (prev_run_q[ax] && !item_i.running[ax]) begin
            armed_d[ax]    = 1'b1;
            deadline_d[ax] = item_i.now_ms + {{(TickW-DelayW){1'b0}}, hold_delay_i};
          end
          if (!prev_run_q[ax] && item_i.running[ax]) begin
            armed_d[ax] = 1'b0;
          end
        end
        prev_run_d = item_i.running;
        if (prev_any_q && !any_run) begin
          if (rt_armed_q) begin
            latched_d  = item_i.now_ms - start_q;
            rt_armed_d = 1'b0;
          end
          done_d = 1'b1;
        end
        prev_any_d = any_run;
      end
      FUNC_SERVICE: begin
        // deadline reached when the wrapped difference is not negative
        for (int ax = 0; ax < NumAxes; ax++) begin
          if (armed_q[ax] && !diff[ax][TickW-1]) begin
            pulse[ax]   = item_i.idle[ax];
            armed_d[ax] = 1'b0;
          end
        end
      end
      FUNC_BEGIN: begin
        latched_d  = '0;
        start_d    = item_i.now_ms;
        rt_armed_d = 1'b1;
      end
      FUNC_TAKE: begin
        finished = done_q;
        done_d   = 1'b0;
      end
    endcase
  end

  assign res_o.hold_current    = pulse;
  assign res_o.motion_finished = finished;
  assign res_o.any_running     = any_run;
  assign res_o.last_runtime_ms = latched_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_run_q <= '0;
      armed_q    <= '0;
      prev_any_q <= 1'b0;
      start_q    <= '0;
      latched_q  <= '0;
      rt_armed_q <= 1'b0;
      done_q     <= 1'b0;
      for (int ax = 0; ax < NumAxes; ax++) begin
        deadline_q[ax] <= '0;
      end
    end else if (fire_i) begin
      prev_run_q <= prev_run_d;
      armed_q    <= armed_d;
      prev_any_q <= prev_any_d;
      start_q    <= start_d;
      latched_q  <= latched_d;
      rt_armed_q <= rt_armed_d;
      done_q     <= done_d;
      deadline_q <= deadline_d;
    end
  end

`ifndef SYNTHESIS
  a_take_clears_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && item_i.func == FUNC_TAKE |=> !done_q)
    else $error("done flag not cleared by take word");

  a_pulse_disarms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && pulse[0] |=> !armed_q[0])
    else $error("axis x still armed after hold pulse");

  a_end_sets_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && item_i.func == FUNC_POLL && prev_any_q && !any_run |=> done_q)
    else $error("motion end did not set done flag");

  a_pulse_only_service: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && item_i.func != FUNC_SERVICE |-> pulse == '0)
    else $error("hold pulse outside service word");
`endif

endmodule

### rtl/motion_idle_hold_timer_core.sv
// top level of the motion idle hold timer: input register, step logic, result register
//
//   channel | dir | fields
//   in_i    | in  | func, now_ms, running_x, running_y, idle_x, idle_y
//   out_o   | out | hold_current_x, hold_current_y, motion_finished, any_running,
//           |     | last_runtime_ms
//   cfg_i   | in  | data (hold_delay_ms)
//
// one word per cycle sustained while results are taken
// the state update happens as a word moves from the input register to the result register
// a stalled result register stops that move, the input register then fills and ready drops
// reset clears all state, hold delay returns to 250 ms; cfg_i is always ready
module motion_idle_hold_timer_core
  import mih_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  mih_in_if.sink    in_i,
  mih_out_if.source out_o,
  mih_cfg_if.sink   cfg_i
);

  logic              in_vld_q;
  item_t             in_q;
  logic              out_vld_q;
  res_t              out_q;
  logic [DelayW-1:0] hold_delay_q;
  logic              adv;
  logic              in_fire;
  res_t              res;

  assign adv        = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || adv;
  assign in_fire    = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q     <= 1'b0;
      out_vld_q    <= 1'b0;
      hold_delay_q <= HoldDelayRst;
    end else begin
      if (in_i.ready) begin
        in_vld_q <= in_i.valid;
      end
      if (adv) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
      if (cfg_i.valid) begin
        hold_delay_q <= cfg_i.data;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_q.func    <= func_e'(in_i.func);
      in_q.now_ms  <= in_i.now_ms;
      in_q.running <= {in_i.running_y, in_i.running_x};
      in_q.idle    <= {in_i.idle_y, in_i.idle_x};
    end
    if (adv) begin
      out_q <= res;
    end
  end

  mih_step u_step (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (adv),
    .item_i       (in_q),
    .hold_delay_i (hold_delay_q),
    .res_o        (res)
  );

  assign out_o.valid           = out_vld_q;
  assign out_o.hold_current_x  = out_q.hold_current[0];
  assign out_o.hold_current_y  = out_q.hold_current[1];
  assign out_o.motion_finished = out_q.motion_finished;
  assign out_o.any_running     = out_q.any_running;
  assign out_o.last_runtime_ms = out_q.last_runtime_ms;

`ifndef SYNTHESIS
  a_ready_means_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> in_vld_q && out_vld_q && !out_o.ready)
    else $error("input stalled without a blocked result");

  a_result_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_o.ready |=> out_vld_q)
    else $error("result lost while stalled");

  a_adv_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_vld_q)
    else $error("advanced word did not reach result register");

  a_result_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> !(out_q.motion_finished && (out_q.hold_current != '0)))
    else $error("take and service results mixed");
`endif

endmodule

### tb/testbench.sv
// self-checking testbench for motion_idle_hold_timer_core: directed table, random motion episodes
`timescale 1ns / 1ps

module testbench;
  import mih_pkg::*;

  localparam int StallCycles = 80;
  localparam int DrainCycles = 8;
  localparam int MaxPrinted  = 30;

  typedef struct packed {
    func_e       func;
    logic [31:0] now_ms;
    logic [1:0]  running;  // bit 0 is axis x
    logic [1:0]  idle;
    logic        pinned;   // want holds a typed-in result
    res_t        want;
  } step_row_t;

  logic clk;
  logic rst_n;

  mih_in_if  in_ch ();
  mih_out_if out_ch ();
  mih_cfg_if cfg_ch ();

  motion_idle_hold_timer_core dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_ch),
    .out_o (out_ch),
    .cfg_i (cfg_ch)
  );

  // predictor copy of the block state
  logic [DelayW-1:0] hold_delay;
  logic [1:0]        axis_moving;
  logic [1:0]        hold_live;
  logic [31:0]       hold_due [2];
  logic              moving_any;
  logic [31:0]       run_t0;
  logic [31:0]       run_len;
  logic              run_timing;
  logic              done_sticky;

  res_t        pending_results [$];
  logic        pin_now;
  res_t        pin_word;
  int          words_sent;
  int          mismatches;
  int          pulses_seen;
  int          takes_seen;
  int          src_idle_pct;
  int          snk_idle_pct;
  logic        rx_hold;
  logic [31:0] tick;
  logic [15:0] mid_delay;
  event        rx_hold_ev;

  step_row_t dir_rows [25] = '{
    '{FUNC_TAKE,    32'h0000_0000, 2'b00, 2'b00, 1'b1, '{2'b00, 1'b0, 1'b0, 32'h0}},
    '{FUNC_SERVICE, 32'hFFFF_FFFF, 2'b11, 2'b11, 1'b1, '{2'b00, 1'b0, 1'b1, 32'h0}},
    '{FUNC_POLL,    32'd100,       2'b11, 2'b00, 1'b1, '{2'b00, 1'b0, 1'b1, 32'h0}},
    '{FUNC_POLL,    32'd200,       2'b00, 2'b11, 1'b1, '{2'b00, 1'b0, 1'b0, 32'h0}},
    '{FUNC_TAKE,    32'd300,       2'b11, 2'b00, 1'b1, '{2'b00, 1'b1, 1'b1, 32'h0}},
    '{FUNC_TAKE,    32'd301,       2'b00, 2'b00, 1'b1, '{2'b00, 1'b0, 1'b0, 32'h0}},
    '{FUNC_SERVICE, 32'd449,       2'b00, 2'b11, 1'b1, '{2'b00, 1'b0, 1'b0, 32'h0}},
    '{FUNC_SERVICE, 32'd450,       2'b00, 2'b01, 1'b1, '{2'b01, 1'b0, 1'b0, 32'h0}},
    '{FUNC_SERVICE, 32'd451,       2'b00, 2'b11, 1'b1, '{2'b00, 1'b0, 1'b0, 32'h0}},
    '{FUNC_BEGIN,   32'hFFFF_FF00, 2'b01, 2'b00, 1'b1, '{2'b00, 1'b0, 1'b1, 32'h0}},
    '{FUNC_POLL,    32'hFFFF_FF10, 2'b01, 2'b00, 1'b1, '{2'b00, 1'b0, 1'b1, 32'h0}},
    '{FUNC_BEGIN,   32'hFFFF_FFF0, 2'b00, 2'b00, 1'b1, '{2'b00, 1'b0, 1'b0, 32'h0}},
    // runtime measured across the tick wrap
    '{FUNC_POLL,    32'h0000_0010, 2'b00, 2'b00, 1'b1, '{2'b00, 1'b0, 1'b0, 32'h20}},
    '{FUNC_TAKE,    32'h0000_0000, 2'b00, 2'b00, 1'b1, '{2'b00, 1'b1, 1'b0, 32'h20}},
    '{FUNC_SERVICE, 32'h8000_010A, 2'b00, 2'b11, 1'b1, '{2'b00, 1'b0, 1'b0, 32'h20}},
    '{FUNC_SERVICE, 32'h8000_0109, 2'b00, 2'b01, 1'b1, '{2'b01, 1'b0, 1'b0, 32'h20}},
    '{FUNC_POLL,    32'hFFFF_FFFF, 2'b10, 2'b00, 1'b1, '{2'b00, 1'b0, 1'b1, 32'h20}},
    // motion end with no begin keeps the old runtime, y deadline wraps to 249
    '{FUNC_POLL,    32'hFFFF_FFFF, 2'b00, 2'b00, 1'b1, '{2'b00, 1'b0, 1'b0, 32'h20}},
    '{FUNC_SERVICE, 32'h0000_00F8, 2'b00, 2'b11, 1'b1, '{2'b00, 1'b0, 1'b0, 32'h20}},
    '{FUNC_SERVICE, 32'h0000_00F9, 2'b00, 2'b01, 1'b1, '{2'b00, 1'b0, 1'b0, 32'h20}},
    '{FUNC_SERVICE, 32'h0000_00F9, 2'b00, 2'b11, 1'b1, '{2'b00, 1'b0, 1'b0, 32'h20}},
    '{FUNC_POLL,    32'd5,         2'b11, 2'b00, 1'b1, '{2'b00, 1'b0, 1'b1, 32'h20}},
    '{FUNC_POLL,    32'd6,         2'b10, 2'b11, 1'b0, '{2'b00, 1'b0, 1'b0, 32'h0}},
    '{FUNC_POLL,    32'd7,         2'b01, 2'b11, 1'b0, '{2'b00, 1'b0, 1'b0, 32'h0}},
    '{FUNC_TAKE,    32'd8,         2'b00, 2'b00, 1'b1, '{2'b00, 1'b1, 1'b0, 32'h20}}
  };

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("motion_idle_hold_timer_core verification failed");
    $finish;
  end

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MaxPrinted) $display("%0t ns: %s", $time, msg);
  endtask

  task automatic clear_hold_model();
    hold_delay   = HoldDelayRst;
    axis_moving  = '0;
    hold_live    = '0;
    hold_due[0]  = '0;
    hold_due[1]  = '0;
    moving_any   = 1'b0;
    run_t0       = '0;
    run_len      = '0;
    run_timing   = 1'b0;
    done_sticky  = 1'b0;
  endtask

  function automatic res_t predict_hold_word(input item_t w);
    res_t        r;
    logic        any;
    logic [31:0] since;
    r = '0;
    any = |w.running;
    case (w.func)
      FUNC_POLL: begin
        for (int ax = 0; ax < 2; ax++) begin
          if (axis_moving[ax] && !w.running[ax]) begin
            hold_live[ax] = 1'b1;
            hold_due[ax]  = w.now_ms + 32'(hold_delay);
          end
          if (!axis_moving[ax] && w.running[ax]) hold_live[ax] = 1'b0;
          axis_moving[ax] = w.running[ax];
        end
        if (moving_any && !any) begin
          if (run_timing) begin
            run_len    = w.now_ms - run_t0;
            run_timing = 1'b0;
          end
          done_sticky = 1'b1;
        end
        moving_any = any;
      end
      FUNC_SERVICE: begin
        for (int ax = 0; ax < 2; ax++) begin
          since = w.now_ms - hold_due[ax];
          // deadline reached when the wrapped difference is not negative
          if (hold_live[ax] && !since[31]) begin
            r.hold_current[ax] = w.idle[ax];
            hold_live[ax]      = 1'b0;
          end
        end
      end
      FUNC_BEGIN: begin
        run_len    = '0;
        run_t0     = w.now_ms;
        run_timing = 1'b1;
      end
      default: begin
        r.motion_finished = done_sticky;
        done_sticky       = 1'b0;
      end
    endcase
    r.any_running     = any;
    r.last_runtime_ms = run_len;
    return r;
  endfunction

  // accepted words feed the predictor, accepted results are checked in order
  always @(posedge clk) begin
    item_t w;
    res_t  predicted;
    res_t  want;
    if (!rst_n) begin
      clear_hold_model();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) hold_delay = cfg_ch.data;
      if (in_ch.valid && in_ch.ready) begin
        w.func    = func_e'(in_ch.func);
        w.now_ms  = in_ch.now_ms;
        w.running = {in_ch.running_y, in_ch.running_x};
        w.idle    = {in_ch.idle_y, in_ch.idle_x};
        predicted = predict_hold_word(w);
        pending_results.push_back(pin_now ? pin_word : predicted);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (out_ch.hold_current_x || out_ch.hold_current_y) pulses_seen++;
        if (out_ch.motion_finished) takes_seen++;
        if (pending_results.size() == 0) begin
          note_mismatch("result word with nothing expected");
        end else begin
          want = pending_results.pop_front();
          if (out_ch.hold_current_x !== want.hold_current[0])
            note_mismatch($sformatf("hold_current_x got %b want %b",
                                    out_ch.hold_current_x, want.hold_current[0]));
          if (out_ch.hold_current_y !== want.hold_current[1])
            note_mismatch($sformatf("hold_current_y got %b want %b",
                                    out_ch.hold_current_y, want.hold_current[1]));
          if (out_ch.motion_finished !== want.motion_finished)
            note_mismatch($sformatf("motion_finished got %b want %b",
                                    out_ch.motion_finished, want.motion_finished));
          if (out_ch.any_running !== want.any_running)
            note_mismatch($sformatf("any_running got %b want %b",
                                    out_ch.any_running, want.any_running));
          if (out_ch.last_runtime_ms !== want.last_runtime_ms)
            note_mismatch($sformatf("last_runtime_ms got %0d want %0d",
                                    out_ch.last_runtime_ms, want.last_runtime_ms));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || rx_hold) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  // long receiver hold-off, counted here so the sender keeps pushing meanwhile
  initial begin
    rx_hold = 1'b0;
    forever begin
      @(rx_hold_ev);
      rx_hold <= 1'b1;
      repeat (StallCycles) @(posedge clk);
      rx_hold <= 1'b0;
    end
  end

  task automatic send_word(input func_e f, input logic [31:0] now, input logic [1:0] run,
                           input logic [1:0] idl, input logic pin = 1'b0,
                           input res_t want = '0);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.func      <= f;
    in_ch.now_ms    <= now;
    in_ch.running_x <= run[0];
    in_ch.running_y <= run[1];
    in_ch.idle_x    <= idl[0];
    in_ch.idle_y    <= idl[1];
    pin_now         <= pin;
    pin_word        <= want;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic send_noise();
    send_word(func_e'($urandom_range(0, 3)), $urandom, 2'($urandom_range(0, 3)),
              2'($urandom_range(0, 3)));
  endtask

  // optional begin, motion, stop, services around the deadline, optional take
  task automatic motion_episode();
    int          n;
    logic [31:0] svc;
    logic [1:0]  idl;
    if ($urandom_range(3) != 0)
      send_word(FUNC_BEGIN, tick, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
    n = $urandom_range(1, 4);
    repeat (n) begin
      tick += $urandom_range(0, 40);
      send_word(FUNC_POLL, tick, 2'($urandom_range(1, 3)), 2'($urandom_range(0, 3)));
    end
    if ($urandom_range(1) != 0) begin
      tick += $urandom_range(0, 40);
      send_word(FUNC_POLL, tick, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
    end
    tick += $urandom_range(0, 40);
    send_word(FUNC_POLL, tick, 2'b00, 2'($urandom_range(0, 3)));
    n = $urandom_range(1, 3);
    repeat (n) begin
      case ($urandom_range(3))
        0:       svc = tick + $urandom_range(0, hold_delay);
        1:       svc = tick + 32'(hold_delay) - 32'd1;
        2:       svc = tick + 32'(hold_delay);
        default: svc = tick + 32'(hold_delay) + $urandom_range(0, 100);
      endcase
      idl = ($urandom_range(3) != 0) ? 2'b11 : 2'($urandom_range(0, 3));
      send_word(FUNC_SERVICE, svc, 2'($urandom_range(0, 3)), idl);
    end
    tick += 32'(hold_delay) + $urandom_range(0, 120);
    if ($urandom_range(1) != 0)
      send_word(FUNC_TAKE, tick, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
  endtask

  task automatic random_until(input int target);
    while (words_sent < target) begin
      if ($urandom_range(9) < 8) motion_episode();
      else repeat ($urandom_range(1, 3)) send_noise();
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_hold_delay(input logic [15:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.func      = FUNC_POLL;
    in_ch.now_ms    = '0;
    in_ch.running_x = 1'b0;
    in_ch.running_y = 1'b0;
    in_ch.idle_x    = 1'b0;
    in_ch.idle_y    = 1'b0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.data     = '0;
    pin_now         = 1'b0;
    pin_word        = '0;
    words_sent      = 0;
    mismatches      = 0;
    pulses_seen     = 0;
    takes_seen      = 0;
    src_idle_pct    = 29;
    snk_idle_pct    = 66;
    mid_delay       = 16'($urandom_range(1, 65534));
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed words run on the reset hold delay
    foreach (dir_rows[i])
      send_word(dir_rows[i].func, dir_rows[i].now_ms, dir_rows[i].running, dir_rows[i].idle,
                dir_rows[i].pinned, dir_rows[i].want);
    drain();
    write_hold_delay(16'd0);
    tick = $urandom;
    random_until(200);

    drain();
    write_hold_delay(16'hFFFF);
    src_idle_pct = 66;
    snk_idle_pct = 29;
    tick = 32'hFFFF_0000;
    random_until(380);

    drain();
    write_hold_delay(mid_delay);
    src_idle_pct = 0;
    snk_idle_pct = 0;
    tick = $urandom;
    -> rx_hold_ev;
    random_until(400);
    // sender waits for every result before going on
    drain();
    random_until(560);
    drain();

    $display("sent %0d words over hold delays 250, 0, 65535 and %0d", words_sent, mid_delay);
    $display("saw %0d hold pulse words and %0d done flags taken", pulses_seen, takes_seen);
    if (mismatches == 0) begin
      $display("motion_idle_hold_timer_core verification clean");
    end else begin
      $display("motion_idle_hold_timer_core verification failed");
    end
    $finish;
  end

endmodule

### motion_idle_hold_timer_core.f
rtl/mih_pkg.sv
rtl/mih_if.sv
rtl/mih_step.sv
rtl/motion_idle_hold_timer_core.sv
tb/testbench.sv
